/* rtl/fvcw_pkg.sv */
package fvcw_pkg;

  // Default geometry of the datapath.
  localparam int FLOW_BITS    = 16;
  localparam int ANGLE_STAGES = 16;

  // Full-scale length register.
  localparam int SCALE_BITS = 17;
  localparam logic [SCALE_BITS-1:0] FULL_SCALE_RESET = 17'd192;

  // Angle unit: 1/65536 of 60 degrees; a full turn is six sectors.
  localparam int ZW          = 21;
  localparam int SECTOR_BITS = 16;
  localparam int SAT_BITS    = 17;
  localparam int QUOT_BITS   = 18;
  localparam logic signed [ZW-1:0] HALF_TURN  = 21'sd196608;
  localparam logic signed [ZW-1:0] TURN_UNITS = 21'sd393216;

  // Arctangent of 2^-i in angle units, one entry per CORDIC cell.
  localparam int ATAN_LEN  = 24;
  localparam int ATAN_BITS = 16;
  localparam logic [ATAN_BITS-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
    16'd49152, 16'd29016, 16'd15331, 16'd7782, 16'd3906, 16'd1955, 16'd978, 16'd489,
    16'd244,   16'd122,   16'd61,    16'd31,   16'd15,   16'd8,    16'd4,   16'd2,
    16'd1,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0,    16'd0,   16'd0
  };

  // Hue sectors of 60 degrees each.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

endpackage

/* rtl/fvcw_in_if.sv */
interface fvcw_in_if #(
  parameter int FLOW_BITS = fvcw_pkg::FLOW_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [FLOW_BITS-1:0] flow_dx;
  logic signed [FLOW_BITS-1:0] flow_dy;
  logic signed [FLOW_BITS-1:0] ref_dx;
  logic signed [FLOW_BITS-1:0] ref_dy;
  logic                        invalid;

  modport source (output valid, flow_dx, flow_dy, ref_dx, ref_dy, invalid, input ready);
  modport sink   (input valid, flow_dx, flow_dy, ref_dx, ref_dy, invalid, output ready);
endinterface

/* rtl/fvcw_out_if.sv */
interface fvcw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

/* rtl/fvcw_cordic_cell.sv */
module fvcw_cordic_cell #(
  parameter int CW  = 36,
  parameter int PW  = 35,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [CW-1:0]        x_in,
  input  logic signed [CW-1:0]        y_in,
  input  logic signed [fvcw_pkg::ZW-1:0] z_in,
  input  logic [PW-1:0]               pass_in,
  output logic signed [CW-1:0]        x_out,
  output logic signed [CW-1:0]        y_out,
  output logic signed [fvcw_pkg::ZW-1:0] z_out,
  output logic [PW-1:0]               pass_out
);

  logic signed [CW-1:0]           xs;
  logic signed [CW-1:0]           ys;
  logic signed [fvcw_pkg::ZW-1:0] step;

  // Floor shifts of the old vector and this cell's rotation angle.
  always_comb begin
    xs   = x_in >>> IDX;
    ys   = y_in >>> IDX;
    step = $signed({{(fvcw_pkg::ZW - fvcw_pkg::ATAN_BITS){1'b0}}, fvcw_pkg::ATAN_TAB[IDX]});
  end

  // Rotate toward the x axis and accumulate the angle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[CW-1]) begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + step;
      end else begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - step;
      end
      pass_out <= pass_in;
    end
  end

endmodule

/* rtl/fvcw_sqrt_cell.sv */
module fvcw_sqrt_cell #(
  parameter int VW = 49,
  parameter int RW = 25,
  parameter int K  = 0,
  parameter int PW = 23
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] rem_in,
  input  logic [RW-1:0] root_in,
  input  logic [PW-1:0] pass_in,
  output logic [VW-1:0] rem_out,
  output logic [RW-1:0] root_out,
  output logic [PW-1:0] pass_out
);

  localparam int TW = 2 * RW + 2;

  logic [TW-1:0] trial;
  logic          take;

  // Trial term (2*root + 2^K) * 2^K against the remaining radicand.
  always_comb begin
    trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));
    take  = TW'(rem_in) >= trial;
  end

  // Settle one root bit.
  always_ff @(posedge clk) begin
    if (en) begin
      if (take) begin
        rem_out  <= rem_in - trial[VW-1:0];
        root_out <= root_in | (RW'(1) << K);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
      pass_out <= pass_in;
    end
  end

endmodule

/* rtl/fvcw_div_cell.sv */
module fvcw_div_cell #(
  parameter int NW = 33,
  parameter int K  = 0,
  parameter int PW = 23
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [fvcw_pkg::SCALE_BITS-1:0]   divisor,
  input  logic [NW-1:0]                     rem_in,
  input  logic [fvcw_pkg::QUOT_BITS-1:0]    quot_in,
  input  logic [PW-1:0]                     pass_in,
  output logic [NW-1:0]                     rem_out,
  output logic [fvcw_pkg::QUOT_BITS-1:0]    quot_out,
  output logic [PW-1:0]                     pass_out
);

  localparam int DVW = NW + fvcw_pkg::SCALE_BITS + fvcw_pkg::QUOT_BITS;

  logic [DVW-1:0] shifted;
  logic           take;

  // Compare against the divisor aligned to this quotient bit.
  always_comb begin
    shifted = DVW'(divisor) << K;
    take    = DVW'(rem_in) >= shifted;
  end

  // Restoring step: one quotient bit per cell.
  always_ff @(posedge clk) begin
    if (en) begin
      if (take) begin
        rem_out  <= rem_in - shifted[NW-1:0];
        quot_out <= quot_in | (fvcw_pkg::QUOT_BITS'(1) << K);
      end else begin
        rem_out  <= rem_in;
        quot_out <= quot_in;
      end
      pass_out <= pass_in;
    end
  end

endmodule

/* rtl/flow_vector_color_wheel.sv */
// Channel     Dir  Fields                                   Handshake
// pixel_in    in   flow_dx, flow_dy, ref_dx, ref_dy, invalid  valid/ready
// color_out   out  red, green, blue                         valid/ready
// cfg_wr      in   full_scale_length                        cfg_wr_en strobe
//
// One item is accepted per clock cycle while pixel_in.ready is high, and it moves
// one cell down the row per cycle while the row is not held. The row holds ANGLE_STAGES
// CORDIC cells, RW = (2*FLOW_BITS + 18) / 2 square-root cells and 18 divider cells.
// Reset clears the valid bits and loads full_scale_length with 192.
// A stalled output parks one item in a skid register; pixel_in.ready drops
// only while that register is full, and then the whole row holds.
module flow_vector_color_wheel #(
  parameter int FLOW_BITS    = fvcw_pkg::FLOW_BITS,
  parameter int ANGLE_STAGES = fvcw_pkg::ANGLE_STAGES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [fvcw_pkg::SCALE_BITS-1:0] cfg_wr_data,
  fvcw_in_if.sink                         pixel_in,
  fvcw_out_if.source                      color_out
);

  localparam int DW  = FLOW_BITS + 1;
  localparam int AW  = FLOW_BITS;
  localparam int CW  = FLOW_BITS + ANGLE_STAGES + 4;
  localparam int ZW  = fvcw_pkg::ZW;
  localparam int SB  = fvcw_pkg::SCALE_BITS;
  localparam int SQW = 2 * AW;
  localparam int VW  = SQW + 1 + 16;
  localparam int RW  = (VW + 1) / 2;
  localparam int NW  = RW + 8;
  localparam int QB  = fvcw_pkg::QUOT_BITS;
  localparam int STB = fvcw_pkg::SAT_BITS;
  localparam int PWC = 2 * AW + 3;
  localparam int PWS = 6 + STB;
  localparam int CMW = AW + SB;
  localparam int LAT = 4 + ANGLE_STAGES + RW + QB;

  logic [SB-1:0]  full_scale_length;
  logic           en;
  logic [LAT-1:0] vld;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_length <= fvcw_pkg::FULL_SCALE_RESET;
    end else if (cfg_wr_en) begin
      full_scale_length <= cfg_wr_data;
    end
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pixel_in.valid};
    end
  end

  // Front end: difference, magnitudes and half-plane fold.
  logic signed [DW-1:0] dx, dy, cx, cy;
  logic [AW-1:0]        mag_x, mag_y;
  logic                 dx_neg, big, zero;

  always_comb begin
    dx     = DW'(pixel_in.flow_dx) - DW'(pixel_in.ref_dx);
    dy     = DW'(pixel_in.flow_dy) - DW'(pixel_in.ref_dy);
    dx_neg = dx[DW-1];
    cx     = dx_neg ? -dx : dx;
    cy     = dx_neg ? -dy : dy;
    mag_x  = cx[AW-1:0];
    mag_y  = dy[DW-1] ? AW'(-dy) : dy[AW-1:0];
    big    = (CMW'(mag_x) >= CMW'(full_scale_length)) ||
             (CMW'(mag_y) >= CMW'(full_scale_length));
    zero   = (dx == '0) && (dy == '0);
  end

  logic signed [CW-1:0] s0_x, s0_y;
  logic signed [ZW-1:0] s0_z;
  logic [PWC-1:0]       s0_pass;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x    <= $signed({{3{cx[DW-1]}}, cx, {ANGLE_STAGES{1'b0}}});
      s0_y    <= $signed({{3{cy[DW-1]}}, cy, {ANGLE_STAGES{1'b0}}});
      s0_z    <= dx_neg ? fvcw_pkg::HALF_TURN : '0;
      s0_pass <= {mag_x, mag_y, big, pixel_in.invalid, zero};
    end
  end

  // CORDIC row.
  logic signed [CW-1:0] c_x [0:ANGLE_STAGES];
  logic signed [CW-1:0] c_y [0:ANGLE_STAGES];
  logic signed [ZW-1:0] c_z [0:ANGLE_STAGES];
  logic [PWC-1:0]       c_pass [0:ANGLE_STAGES];

  assign c_x[0]    = s0_x;
  assign c_y[0]    = s0_y;
  assign c_z[0]    = s0_z;
  assign c_pass[0] = s0_pass;

  for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cordic
    fvcw_cordic_cell #(.CW(CW), .PW(PWC), .IDX(i)) u_cell (
      .clk      (clk),
      .en       (en),
      .x_in     (c_x[i]),
      .y_in     (c_y[i]),
      .z_in     (c_z[i]),
      .pass_in  (c_pass[i]),
      .x_out    (c_x[i+1]),
      .y_out    (c_y[i+1]),
      .z_out    (c_z[i+1]),
      .pass_out (c_pass[i+1])
    );
  end

  // Angle wrap, sector split and squares of the magnitudes.
  logic signed [ZW-1:0] z_wrap;
  logic [2:0]           sector;
  logic [STB-1:0]       f16;
  logic [AW-1:0]        ca, cb;

  always_comb begin
    if (c_z[ANGLE_STAGES] < 0) begin
      z_wrap = c_z[ANGLE_STAGES] + fvcw_pkg::TURN_UNITS;
    end else if (c_z[ANGLE_STAGES] >= fvcw_pkg::TURN_UNITS) begin
      z_wrap = c_z[ANGLE_STAGES] - fvcw_pkg::TURN_UNITS;
    end else begin
      z_wrap = c_z[ANGLE_STAGES];
    end
    sector = z_wrap[fvcw_pkg::SECTOR_BITS+2:fvcw_pkg::SECTOR_BITS];
    f16    = sector[0] ? {1'b0, z_wrap[fvcw_pkg::SECTOR_BITS-1:0]}
                       : (STB'(1) << 16) - STB'(z_wrap[fvcw_pkg::SECTOR_BITS-1:0]);
    ca     = c_pass[ANGLE_STAGES][PWC-1 -: AW];
    cb     = c_pass[ANGLE_STAGES][PWC-1-AW -: AW];
  end

  logic [SQW-1:0] s1_sqa, s1_sqb;
  logic [PWS-1:0] s1_pass;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sqa  <= SQW'(ca) * SQW'(ca);
      s1_sqb  <= SQW'(cb) * SQW'(cb);
      s1_pass <= {c_pass[ANGLE_STAGES][2:0], sector, f16};
    end
  end

  // Radicand: squared length scaled by 2^16.
  logic [VW-1:0]  s2_v;
  logic [PWS-1:0] s2_pass;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_v    <= {(SQW + 1)'(s1_sqa) + (SQW + 1)'(s1_sqb), 16'b0};
      s2_pass <= s1_pass;
    end
  end

  // Square root row, one bit per cell.
  logic [VW-1:0]  r_rem  [0:RW];
  logic [RW-1:0]  r_root [0:RW];
  logic [PWS-1:0] r_pass [0:RW];

  assign r_rem[0]  = s2_v;
  assign r_root[0] = '0;
  assign r_pass[0] = s2_pass;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    fvcw_sqrt_cell #(.VW(VW), .RW(RW), .K(RW - 1 - j), .PW(PWS)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (r_rem[j]),
      .root_in  (r_root[j]),
      .pass_in  (r_pass[j]),
      .rem_out  (r_rem[j+1]),
      .root_out (r_root[j+1]),
      .pass_out (r_pass[j+1])
    );
  end

  // Divider row: length * 65536 / full_scale_length; a quotient of 2^16 or more counts as overflow.
  logic [NW-1:0]  d_rem  [0:QB];
  logic [QB-1:0]  d_quot [0:QB];
  logic [PWS-1:0] d_pass [0:QB];

  assign d_rem[0]  = {r_root[RW], 8'b0};
  assign d_quot[0] = '0;
  assign d_pass[0] = r_pass[RW];

  for (genvar k = 0; k < QB; k++) begin : g_div
    fvcw_div_cell #(.NW(NW), .K(QB - 1 - k), .PW(PWS)) u_cell (
      .clk      (clk),
      .en       (en),
      .divisor  (full_scale_length),
      .rem_in   (d_rem[k]),
      .quot_in  (d_quot[k]),
      .pass_in  (d_pass[k]),
      .rem_out  (d_rem[k+1]),
      .quot_out (d_quot[k+1]),
      .pass_out (d_pass[k+1])
    );
  end

  // Saturation clamp, sat*f16 product and the m channel.
  logic [STB-1:0] sat, sat_inv;
  logic [24:0]    m_scaled;
  logic           d_big;

  always_comb begin
    d_big    = d_pass[QB][PWS-1];
    sat      = (d_big || (d_quot[QB] >= (QB'(1) << 16))) ? (STB'(1) << 16)
                                                       : d_quot[QB][STB-1:0];
    sat_inv  = (STB'(1) << 16) - sat;
    m_scaled = {sat_inv, 8'b0} - {8'b0, sat_inv};
  end

  logic [33:0] s3_prod;
  logic [7:0]  s3_mb;
  logic [2:0]  s3_sector;
  logic        s3_inv, s3_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_prod   <= 34'(sat) * 34'(d_pass[QB][STB-1:0]);
      s3_mb     <= m_scaled[23:16];
      s3_sector <= d_pass[QB][STB+2:STB];
      s3_inv    <= d_pass[QB][PWS-2];
      s3_zero   <= d_pass[QB][PWS-3];
    end
  end

  // X channel and channel order by sector.
  logic [32:0] x_rest;
  logic [40:0] x_scaled;
  logic [7:0]  xb;
  logic [7:0]  new_r, new_g, new_b;

  always_comb begin
    x_rest   = (33'd1 << 32) - s3_prod[32:0];
    x_scaled = {x_rest, 8'b0} - {8'b0, x_rest};
    xb       = x_scaled[39:32];
    unique case (fvcw_pkg::sector_t'(s3_sector))
      fvcw_pkg::SEC_RED_YELLOW:   begin new_r = 8'd255; new_g = xb;     new_b = s3_mb;  end
      fvcw_pkg::SEC_YELLOW_GREEN: begin new_r = xb;     new_g = 8'd255; new_b = s3_mb;  end
      fvcw_pkg::SEC_GREEN_CYAN:   begin new_r = s3_mb;  new_g = 8'd255; new_b = xb;     end
      fvcw_pkg::SEC_CYAN_BLUE:    begin new_r = s3_mb;  new_g = xb;     new_b = 8'd255; end
      fvcw_pkg::SEC_BLUE_MAGENTA: begin new_r = xb;     new_g = s3_mb;  new_b = 8'd255; end
      default:                    begin new_r = 8'd255; new_g = s3_mb;  new_b = xb;     end
    endcase
    if (s3_inv) begin
      new_r = 8'd0;
      new_g = 8'd0;
      new_b = 8'd0;
    end else if (s3_zero) begin
      new_r = 8'd255;
      new_g = 8'd255;
      new_b = 8'd255;
    end
  end

  // Output register with a skid register behind it.
  logic       out_valid, skid_valid;
  logic [7:0] out_r, out_g, out_b;
  logic [7:0] skid_r, skid_g, skid_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (color_out.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_r      <= skid_r;
        out_g      <= skid_g;
        out_b      <= skid_b;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= vld[LAT-1];
        out_r     <= new_r;
        out_g     <= new_g;
        out_b     <= new_b;
      end
    end else if (vld[LAT-1] && en) begin
      skid_valid <= 1'b1;
      skid_r     <= new_r;
      skid_g     <= new_g;
      skid_b     <= new_b;
    end
  end

  assign en              = !skid_valid;
  assign pixel_in.ready  = en;
  assign color_out.valid = out_valid;
  assign color_out.red   = out_r;
  assign color_out.green = out_g;
  assign color_out.blue  = out_b;

endmodule

/* rtl/fvcw_checker.sv */
module fvcw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue
);

  // A stalled result item keeps its color.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(red) && $stable(green) && $stable(blue)))
    else $error("result item changed while stalled");

  // Every color is black or has one channel at full scale.
  a_full_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == 8'd255 || green == 8'd255 || blue == 8'd255 ||
                   (red == 8'd0 && green == 8'd0 && blue == 8'd0)))
    else $error("color without a full channel");

  // Input back-pressure only follows an output stall.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without output stall");

  // No result item right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result item right after reset");

endmodule

bind flow_vector_color_wheel fvcw_checker u_fvcw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixel_in.ready),
  .out_valid (color_out.valid),
  .out_ready (color_out.ready),
  .red       (color_out.red),
  .green     (color_out.green),
  .blue      (color_out.blue)
);
